/* src/dsched_pkg.sv */
`default_nettype none

package dsched_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int BLOCK_BITS  = 16;
    localparam int TAG_BITS    = 8;
    localparam int TOTAL_BITS  = 48;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] POL_FCFS   = 2'd0;
    localparam logic [1:0] POL_SSTF   = 2'd1;
    localparam logic [1:0] POL_CSCAN  = 2'd2;
    localparam logic [1:0] POL_RESET  = POL_SSTF;

    localparam logic OP_ENQUEUE  = 1'b0;
    localparam logic OP_DISPATCH = 1'b1;

    typedef enum logic [1:0] {
        ST_ENQUEUED   = 2'd0,
        ST_FULL       = 2'd1,
        ST_DISPATCHED = 2'd2,
        ST_EMPTY      = 2'd3
    } status_t;

    typedef struct packed {
        logic                  operation;
        logic [BLOCK_BITS-1:0] block_number;
        logic                  is_write;
        logic [TAG_BITS-1:0]   requester_tag;
    } item_t;

    typedef struct packed {
        status_t               status;
        logic [BLOCK_BITS-1:0] chosen_block;
        logic                  chosen_is_write;
        logic [TAG_BITS-1:0]   chosen_tag;
        logic [BLOCK_BITS-1:0] seek_distance;
        logic [TOTAL_BITS-1:0] total_movement;
        logic [CNT_W-1:0]      pending_count;
    } result_t;

    typedef struct packed {
        logic [BLOCK_BITS-1:0] blk;
        logic                  wr;
        logic [TAG_BITS-1:0]   tag;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SELECT,
        S_CAPTURE,
        S_SHIFT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic enqueue;
        logic empty_reply;
        logic scan_start;
        logic scan_run;
        logic select;
        logic capture;
        logic shift_run;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic count_zero;
        logic walk_done;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

/* src/disk_request_scheduler_unit.sv */
// Enqueue, and dispatch on an empty queue: result registered the cycle after the item is taken.
// Dispatch on a non-empty queue: every entry is scored, the chosen slot is read and captured,
// the entries above it move down (none when the newest is chosen), the result is registered;
// the single RAM read port is walked once to score every entry and once to close the gap.
// One item in flight; the next is taken once the block is idle and the result slot is free.
// rst_n (async, active low) empties the queue, parks the head at block 0, clears the movement
// total and selects shortest seek first; queue RAM contents are not cleared.
`default_nettype none

module disk_request_scheduler_unit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_stall,
    input  wire dsched_pkg::item_t   item,
    output logic                     result_valid,
    input  wire logic                result_stall,
    output dsched_pkg::result_t      result,
    input  wire logic                policy_valid,
    output logic                     policy_ready,
    input  wire logic [1:0]          policy
);
    import dsched_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign policy_ready = 1'b1;

    dsched_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .operation  (item.operation),
        .sts        (sts),
        .cmd        (cmd)
    );

    dsched_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .item         (item),
        .policy_wr    (policy_valid && policy_ready),
        .policy_data  (policy),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

/* src/dsched_ram.sv */
`default_nettype none

module dsched_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* src/dsched_ctrl.sv */
`default_nettype none

module dsched_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    output logic               item_stall,
    input  wire logic          operation,
    input  wire dsched_pkg::sts_t sts,
    output dsched_pkg::cmd_t   cmd
);
    import dsched_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign item_stall = !((state_reg == S_IDLE) && sts.out_free);
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (operation == OP_DISPATCH) && !sts.count_zero)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.walk_done)
                begin
                    state_next = S_SELECT;
                end
            end
            S_SELECT:  state_next = S_CAPTURE;
            S_CAPTURE: state_next = S_SHIFT;
            S_SHIFT:
            begin
                if (sts.walk_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (operation == OP_ENQUEUE)
                    begin
                        cmd.enqueue = 1'b1;
                    end
                    else if (sts.count_zero)
                    begin
                        cmd.empty_reply = 1'b1;
                    end
                    else
                    begin
                        cmd.scan_start = 1'b1;
                    end
                end
            end
            S_SCAN:    cmd.scan_run  = 1'b1;
            S_SELECT:  cmd.select    = 1'b1;
            S_CAPTURE: cmd.capture   = 1'b1;
            S_SHIFT:   cmd.shift_run = 1'b1;
            S_DONE:    cmd.finish    = sts.out_free;
            default:   cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* src/dsched_dp.sv */
`default_nettype none

module dsched_dp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dsched_pkg::cmd_t   cmd,
    output dsched_pkg::sts_t        sts,
    input  wire dsched_pkg::item_t  item,
    input  wire logic               policy_wr,
    input  wire logic [1:0]         policy_data,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output dsched_pkg::result_t     result
);
    import dsched_pkg::*;

    // control state
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [BLOCK_BITS-1:0] head_reg, head_next;
    logic [TOTAL_BITS-1:0] total_reg, total_next;
    logic [1:0]            policy_reg, policy_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic                  pend_reg, pend_next;
    logic                  up_found_reg, up_found_next;
    logic                  result_valid_reg, result_valid_next;

    // payload
    logic [IDX_W-1:0]      pend_idx_reg, pend_idx_next;
    logic [BLOCK_BITS-1:0] best_d_reg, best_d_next;
    logic [IDX_W-1:0]      best_idx_reg, best_idx_next;
    logic [BLOCK_BITS-1:0] up_d_reg, up_d_next;
    logic [IDX_W-1:0]      up_idx_reg, up_idx_next;
    logic [BLOCK_BITS-1:0] low_b_reg, low_b_next;
    logic [IDX_W-1:0]      low_idx_reg, low_idx_next;
    logic [IDX_W-1:0]      sel_reg, sel_next;
    entry_t                chosen_reg, chosen_next;
    logic [BLOCK_BITS-1:0] seek_reg, seek_next;
    result_t               result_reg, result_next;

    entry_t                rd_data;
    entry_t                wr_data;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;

    logic                  full;
    logic                  walking;
    logic                  issue;
    logic                  eval;
    logic                  first;
    logic                  at_or_above;
    logic [BLOCK_BITS-1:0] gap;
    logic [IDX_W-1:0]      sel_comb;
    logic [TOTAL_BITS:0]   total_sum;
    logic                  out_free;

    assign full        = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign walking     = cmd.scan_run || cmd.shift_run;
    assign issue       = walking && (idx_reg < count_reg);
    assign eval        = cmd.scan_run && pend_reg;
    assign first       = (pend_idx_reg == '0);
    assign at_or_above = (rd_data.blk >= head_reg);
    assign gap         = at_or_above ? (rd_data.blk - head_reg) : (head_reg - rd_data.blk);
    assign out_free    = !result_valid_reg || !result_stall;
    assign total_sum   = {1'b0, total_reg} + (TOTAL_BITS + 1)'(seek_reg);

    always_comb
    begin
        priority case (policy_reg)
            POL_SSTF:  sel_comb = best_idx_reg;
            POL_CSCAN: sel_comb = up_found_reg ? up_idx_reg : low_idx_reg;
            default:   sel_comb = '0;
        endcase
    end

    assign rd_en   = issue || cmd.select;
    assign rd_addr = cmd.select ? sel_comb : idx_reg[IDX_W-1:0];

    // compaction: the entry read last cycle moves one place down
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = pend_idx_reg - IDX_W'(1);
        wr_data = rd_data;
        if (cmd.enqueue && !full)
        begin
            wr_en   = 1'b1;
            wr_addr = count_reg[IDX_W-1:0];
            wr_data = '{blk: item.block_number, wr: item.is_write, tag: item.requester_tag};
        end
        else if (cmd.shift_run && pend_reg)
        begin
            wr_en = 1'b1;
        end
    end

    always_comb
    begin
        count_next        = count_reg;
        head_next         = head_reg;
        total_next        = total_reg;
        policy_next       = policy_reg;
        idx_next          = idx_reg;
        pend_next         = pend_reg;
        up_found_next     = up_found_reg;
        result_valid_next = result_valid_reg;
        pend_idx_next     = pend_idx_reg;
        best_d_next       = best_d_reg;
        best_idx_next     = best_idx_reg;
        up_d_next         = up_d_reg;
        up_idx_next       = up_idx_reg;
        low_b_next        = low_b_reg;
        low_idx_next      = low_idx_reg;
        sel_next          = sel_reg;
        chosen_next       = chosen_reg;
        seek_next         = seek_reg;
        result_next       = result_reg;

        if (policy_wr)
        begin
            policy_next = policy_data;
        end

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        if (cmd.scan_start)
        begin
            idx_next      = '0;
            pend_next     = 1'b0;
            up_found_next = 1'b0;
        end

        if (walking)
        begin
            pend_next     = issue;
            pend_idx_next = idx_reg[IDX_W-1:0];
            if (issue)
            begin
                idx_next = idx_reg + CNT_W'(1);
            end
        end

        // strict compares keep the earliest arrival on ties
        if (eval)
        begin
            if (first || (gap < best_d_reg))
            begin
                best_d_next   = gap;
                best_idx_next = pend_idx_reg;
            end
            if (at_or_above && (!up_found_reg || (gap < up_d_reg)))
            begin
                up_found_next = 1'b1;
                up_d_next     = gap;
                up_idx_next   = pend_idx_reg;
            end
            if (first || (rd_data.blk < low_b_reg))
            begin
                low_b_next   = rd_data.blk;
                low_idx_next = pend_idx_reg;
            end
        end

        if (cmd.select)
        begin
            sel_next = sel_comb;
        end

        if (cmd.capture)
        begin
            chosen_next = rd_data;
            seek_next   = gap;
            idx_next    = CNT_W'(sel_reg) + CNT_W'(1);
            pend_next   = 1'b0;
        end

        if (cmd.enqueue)
        begin
            result_valid_next          = 1'b1;
            result_next                = '0;
            result_next.total_movement = total_reg;
            if (full)
            begin
                result_next.status        = ST_FULL;
                result_next.pending_count = count_reg;
            end
            else
            begin
                count_next                = count_reg + CNT_W'(1);
                result_next.status        = ST_ENQUEUED;
                result_next.pending_count = count_reg + CNT_W'(1);
            end
        end

        if (cmd.empty_reply)
        begin
            result_valid_next          = 1'b1;
            result_next                = '0;
            result_next.status         = ST_EMPTY;
            result_next.total_movement = total_reg;
            result_next.pending_count  = count_reg;
        end

        if (cmd.finish)
        begin
            count_next = count_reg - CNT_W'(1);
            head_next  = chosen_reg.blk;
            if (total_sum[TOTAL_BITS])
            begin
                total_next = '1;
            end
            else
            begin
                total_next = total_sum[TOTAL_BITS-1:0];
            end
            result_valid_next           = 1'b1;
            result_next.status          = ST_DISPATCHED;
            result_next.chosen_block    = chosen_reg.blk;
            result_next.chosen_is_write = chosen_reg.wr;
            result_next.chosen_tag      = chosen_reg.tag;
            result_next.seek_distance   = seek_reg;
            result_next.total_movement  = total_next;
            result_next.pending_count   = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            head_reg         <= '0;
            total_reg        <= '0;
            policy_reg       <= POL_RESET;
            idx_reg          <= '0;
            pend_reg         <= 1'b0;
            up_found_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg        <= count_next;
            head_reg         <= head_next;
            total_reg        <= total_next;
            policy_reg       <= policy_next;
            idx_reg          <= idx_next;
            pend_reg         <= pend_next;
            up_found_reg     <= up_found_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        best_d_reg   <= best_d_next;
        best_idx_reg <= best_idx_next;
        up_d_reg     <= up_d_next;
        up_idx_reg   <= up_idx_next;
        low_b_reg    <= low_b_next;
        low_idx_reg  <= low_idx_next;
        sel_reg      <= sel_next;
        chosen_reg   <= chosen_next;
        seek_reg     <= seek_next;
        result_reg   <= result_next;
    end

    dsched_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign sts.count_zero = (count_reg == '0);
    assign sts.walk_done  = (idx_reg == count_reg) && !pend_reg;
    assign sts.out_free   = out_free;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

/* src/dsched_checker.sv */
`default_nettype none

module dsched_checker (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                result_valid,
    input  wire logic                result_stall,
    input  wire dsched_pkg::result_t result
);
    import dsched_pkg::*;

    // a stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // only a dispatch carries request fields and head movement
    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status != ST_DISPATCHED) |->
            (result.chosen_block == '0) && (result.chosen_tag == '0) &&
            (result.chosen_is_write == 1'b0) && (result.seek_distance == '0))
        else $error("non-dispatch result carries request fields");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status == ST_FULL) |->
            (result.pending_count == CNT_W'(QUEUE_DEPTH)))
        else $error("rejection while queue not full");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status == ST_EMPTY) |-> (result.pending_count == '0))
        else $error("empty reply with requests pending");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status == ST_DISPATCHED) |->
            (result.pending_count < CNT_W'(QUEUE_DEPTH)))
        else $error("pending count out of range after dispatch");

endmodule

bind disk_request_scheduler_unit dsched_checker u_dsched_checker (.*);

`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 100ps

module tb;
    import dsched_pkg::*;

    localparam logic [1:0] POL_SPARE = 2'd3;   // unused code, behaves as FCFS
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 230;
    localparam logic [2*PHASES-1:0] PHASE_POLICY = {POL_SSTF, POL_CSCAN, POL_FCFS, POL_CSCAN,
                                                    POL_SSTF, POL_SPARE, POL_CSCAN, POL_FCFS};

    typedef struct {
        item_t   stim;
        bit      known;
        result_t want;
    } stim_row_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;
    logic    policy_valid = 1'b0;
    logic    policy_ready;
    logic [1:0] policy = POL_RESET;

    // scheduler state as predicted
    entry_t                pend_q[$];
    logic [BLOCK_BITS-1:0] head_blk = '0;
    logic [TOTAL_BITS-1:0] travel_total = '0;
    logic [1:0]            cur_policy = POL_RESET;

    result_t   expected_results[$];
    stim_row_t directed_rows[$];
    int        mismatch_count = 0;
    int        results_seen = 0;
    int        burst_left = 0;
    logic [BLOCK_BITS-1:0] cluster_base = '0;

    disk_request_scheduler_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .policy_valid (policy_valid),
        .policy_ready (policy_ready),
        .policy       (policy)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [BLOCK_BITS-1:0] block_gap(logic [BLOCK_BITS-1:0] a,
                                                        logic [BLOCK_BITS-1:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function automatic result_t predict_schedule(item_t it);
        result_t r;
        entry_t  e;
        int      sel;
        int      i;
        logic    found;
        logic [BLOCK_BITS-1:0] best_gap;
        logic [BLOCK_BITS-1:0] g;
        logic [TOTAL_BITS:0]   sum;
        r = '0;
        if (it.operation == OP_ENQUEUE)
        begin
            if (pend_q.size() >= QUEUE_DEPTH)
                r.status = ST_FULL;
            else
            begin
                e.blk = it.block_number;
                e.wr  = it.is_write;
                e.tag = it.requester_tag;
                pend_q.push_back(e);
                r.status = ST_ENQUEUED;
            end
        end
        else if (pend_q.size() == 0)
            r.status = ST_EMPTY;
        else
        begin
            sel = 0;
            if (cur_policy == POL_SSTF)
            begin
                best_gap = block_gap(pend_q[0].blk, head_blk);
                for (i = 1; i < pend_q.size(); i++)
                begin
                    g = block_gap(pend_q[i].blk, head_blk);
                    if (g < best_gap)
                    begin
                        best_gap = g;
                        sel = i;
                    end
                end
            end
            else if (cur_policy == POL_CSCAN)
            begin
                found = 1'b0;
                best_gap = '0;
                for (i = 0; i < pend_q.size(); i++)
                begin
                    if (pend_q[i].blk >= head_blk)
                    begin
                        g = pend_q[i].blk - head_blk;
                        if (!found || g < best_gap)
                        begin
                            found = 1'b1;
                            best_gap = g;
                            sel = i;
                        end
                    end
                end
                // nothing at or above the head: wrap to the lowest block
                if (!found)
                    for (i = 1; i < pend_q.size(); i++)
                        if (pend_q[i].blk < pend_q[sel].blk)
                            sel = i;
            end
            e = pend_q[sel];
            pend_q.delete(sel);
            r.status          = ST_DISPATCHED;
            r.chosen_block    = e.blk;
            r.chosen_is_write = e.wr;
            r.chosen_tag      = e.tag;
            r.seek_distance   = block_gap(e.blk, head_blk);
            head_blk = e.blk;
            sum = {1'b0, travel_total} + (TOTAL_BITS + 1)'(r.seek_distance);
            travel_total = sum[TOTAL_BITS] ? '1 : sum[TOTAL_BITS-1:0];
        end
        r.total_movement = travel_total;
        r.pending_count  = CNT_W'(pend_q.size());
        return r;
    endfunction

    function automatic item_t mk_item(logic op, logic [BLOCK_BITS-1:0] blk, logic wr,
                                      logic [TAG_BITS-1:0] tag);
        item_t it;
        it.operation     = op;
        it.block_number  = blk;
        it.is_write      = wr;
        it.requester_tag = tag;
        return it;
    endfunction

    function automatic result_t mk_result(status_t st, logic [BLOCK_BITS-1:0] blk, logic wr,
                                          logic [TAG_BITS-1:0] tag, logic [BLOCK_BITS-1:0] seek,
                                          logic [TOTAL_BITS-1:0] total, int count);
        result_t r;
        r.status          = st;
        r.chosen_block    = blk;
        r.chosen_is_write = wr;
        r.chosen_tag      = tag;
        r.seek_distance   = seek;
        r.total_movement  = total;
        r.pending_count   = CNT_W'(count);
        return r;
    endfunction

    task automatic add_row(item_t it, bit known, result_t want);
        stim_row_t row;
        row.stim  = it;
        row.known = known;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    task automatic build_directed();
        logic [BLOCK_BITS-1:0] fill_blk[16];
        int i;
        // duplicates and equal distances to exercise earliest-arrival tie breaks
        fill_blk = '{16'h8000, 16'h0001, 16'hFFFE, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF,
                     16'h1234, 16'hFFFE, 16'hAAAA, 16'h5555, 16'h0000, 16'h8001, 16'hFFFF,
                     16'h00FF, 16'hFF00};
        add_row(mk_item(OP_DISPATCH, 16'h0000, 1'b0, 8'h00), 1'b1,
                mk_result(ST_EMPTY, '0, 1'b0, '0, '0, '0, 0));
        add_row(mk_item(OP_ENQUEUE, 16'hFFFF, 1'b1, 8'hFF), 1'b1,
                mk_result(ST_ENQUEUED, '0, 1'b0, '0, '0, '0, 1));
        add_row(mk_item(OP_ENQUEUE, 16'h0000, 1'b0, 8'h00), 1'b1,
                mk_result(ST_ENQUEUED, '0, 1'b0, '0, '0, '0, 2));
        add_row(mk_item(OP_DISPATCH, 16'hFFFF, 1'b1, 8'hFF), 1'b1,
                mk_result(ST_DISPATCHED, 16'h0000, 1'b0, 8'h00, '0, '0, 1));
        add_row(mk_item(OP_DISPATCH, 16'h5A5A, 1'b0, 8'hA5), 1'b1,
                mk_result(ST_DISPATCHED, 16'hFFFF, 1'b1, 8'hFF, 16'hFFFF, 48'hFFFF, 0));
        for (i = 0; i < 16; i++)
            add_row(mk_item(OP_ENQUEUE, fill_blk[i], i[0], 8'(i * 17)), 1'b0, '0);
        add_row(mk_item(OP_ENQUEUE, 16'h4321, 1'b1, 8'h3C), 1'b1,
                mk_result(ST_FULL, '0, 1'b0, '0, '0, 48'hFFFF, 16));
        add_row(mk_item(OP_DISPATCH, 16'h0000, 1'b0, 8'h00), 1'b0, '0);
        add_row(mk_item(OP_DISPATCH, 16'hFFFF, 1'b1, 8'hFF), 1'b0, '0);
    endtask

    function automatic item_t draw_request(bit filling);
        item_t it;
        int    pick;
        it.requester_tag = 8'($urandom);
        it.is_write      = 1'($urandom);
        pick = $urandom_range(0, 99);
        if (filling)
            it.operation = (pick < 25) ? OP_DISPATCH : OP_ENQUEUE;
        else
            it.operation = (pick < 75) ? OP_DISPATCH : OP_ENQUEUE;
        case ($urandom_range(0, 9))
            0:       it.block_number = '0;
            1:       it.block_number = '1;
            2, 3, 4: it.block_number = cluster_base + 16'($urandom_range(0, 6));
            5, 6:    it.block_number = head_blk + 16'($urandom_range(0, 8)) - 16'(4);
            default: it.block_number = 16'($urandom);
        endcase
        return it;
    endfunction

    task automatic offer_item(item_t it, bit known, result_t want);
        int      gap_len;
        result_t predicted;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            case ($urandom_range(0, 3))
                0:       gap_len = 0;
                1:       gap_len = $urandom_range(7, 45);
                default: gap_len = $urandom_range(1, 6);
            endcase
            if (gap_len > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap_len) @(posedge clk);
            end
        end
        burst_left--;
        item <= it;
        item_valid <= 1'b1;
        do @(posedge clk); while (item_stall);
        predicted = predict_schedule(it);
        expected_results.push_back(known ? want : predicted);
    endtask

    task automatic write_policy(logic [1:0] value);
        policy <= value;
        policy_valid <= 1'b1;
        do @(posedge clk); while (!policy_ready);
        policy_valid <= 1'b0;
        cur_policy = value;
    endtask

    task automatic report_mismatch(string field, logic [TOTAL_BITS-1:0] got,
                                   logic [TOTAL_BITS-1:0] want);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("mismatch on %s: got 0x%0h, want 0x%0h, result %0d", field, got, want,
                     results_seen);
    endtask

    // result side: check accepted items, then pick the next stall value
    initial
    begin
        int      stall_cycle;
        int      stall_mode;
        int      hold_left;
        bit      hold_done;
        result_t want;
        stall_cycle = 0;
        stall_mode = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_valid && !result_stall)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                    report_mismatch("item with nothing pending", result.total_movement, '0);
                else
                begin
                    want = expected_results.pop_front();
                    if (result.status !== want.status)
                        report_mismatch("status", TOTAL_BITS'(result.status),
                                        TOTAL_BITS'(want.status));
                    if (result.chosen_block !== want.chosen_block)
                        report_mismatch("chosen_block", TOTAL_BITS'(result.chosen_block),
                                        TOTAL_BITS'(want.chosen_block));
                    if (result.chosen_is_write !== want.chosen_is_write)
                        report_mismatch("chosen_is_write", TOTAL_BITS'(result.chosen_is_write),
                                        TOTAL_BITS'(want.chosen_is_write));
                    if (result.chosen_tag !== want.chosen_tag)
                        report_mismatch("chosen_tag", TOTAL_BITS'(result.chosen_tag),
                                        TOTAL_BITS'(want.chosen_tag));
                    if (result.seek_distance !== want.seek_distance)
                        report_mismatch("seek_distance", TOTAL_BITS'(result.seek_distance),
                                        TOTAL_BITS'(want.seek_distance));
                    if (result.total_movement !== want.total_movement)
                        report_mismatch("total_movement", result.total_movement,
                                        want.total_movement);
                    if (result.pending_count !== want.pending_count)
                        report_mismatch("pending_count", TOTAL_BITS'(result.pending_count),
                                        TOTAL_BITS'(want.pending_count));
                end
            end
            // one long hold-off so the block backs up and stalls its input
            if (hold_left == 0 && !hold_done && results_seen >= 300)
            begin
                hold_left = 400;
                hold_done = 1'b1;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                stall_cycle++;
                if (stall_cycle % 64 == 0)
                    stall_mode = $urandom_range(0, 3);
                case (stall_mode)
                    0:       result_stall <= 1'b0;
                    1:       result_stall <= ($urandom_range(0, 2) == 0);
                    2:       result_stall <= (stall_cycle % 5 < 2);
                    default: result_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    initial
    begin
        int k;
        int p;
        int n;
        int mode_left;
        bit filling;
        mode_left = 0;
        filling = 1'b0;
        build_directed();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (k = 0; k < directed_rows.size(); k++)
            offer_item(directed_rows[k].stim, directed_rows[k].known, directed_rows[k].want);
        for (p = 0; p < PHASES; p++)
        begin
            // quiet the block before touching the policy
            item_valid <= 1'b0;
            burst_left = 0;
            while (expected_results.size() != 0) @(posedge clk);
            write_policy(PHASE_POLICY[2*p +: 2]);
            cluster_base = 16'($urandom);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (mode_left == 0)
                begin
                    filling = !filling;
                    mode_left = $urandom_range(8, 60);
                end
                mode_left--;
                offer_item(draw_request(filling), 1'b0, '0);
            end
        end
        item_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule
